// ===== hw/rtl/sit_pkg.sv =====
`default_nettype none

package sit_pkg;

	// fixed field and register widths
	localparam int COORD_BITS  = 32;
	localparam int SHRINK_BITS = 20;
	localparam int TOL_BITS    = 40;

	// internal widths: shrunk coordinate, difference, product, cross term
	localparam int SH_W  = ((COORD_BITS > SHRINK_BITS) ? COORD_BITS : SHRINK_BITS) + 1;
	localparam int DIF_W = SH_W + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int CRS_W = ((PRD_W + 1) > (TOL_BITS + 2)) ? (PRD_W + 1) : (TOL_BITS + 2);

	// configuration port
	localparam int CFG_W     = TOL_BITS;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 1'd1;

	localparam logic [SHRINK_BITS-1:0] SHRINK_RST = SHRINK_BITS'(1);
	localparam logic [TOL_BITS-1:0]    TOL_RST    = TOL_BITS'(1099512);

	// orientation codes
	localparam logic [1:0] ORI_ZERO = 2'd0;
	localparam logic [1:0] ORI_POS  = 2'd1;
	localparam logic [1:0] ORI_NEG  = 2'd2;

	// hit case codes
	localparam logic [2:0] HIT_NONE    = 3'd0;
	localparam logic [2:0] HIT_GENERAL = 3'd1;
	localparam logic [2:0] HIT_B_START = 3'd2;
	localparam logic [2:0] HIT_B_END   = 3'd3;
	localparam logic [2:0] HIT_A_START = 3'd4;
	localparam logic [2:0] HIT_A_END   = 3'd5;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] seg_a_start_x;
		logic signed [COORD_BITS-1:0] seg_a_start_y;
		logic signed [COORD_BITS-1:0] seg_a_end_x;
		logic signed [COORD_BITS-1:0] seg_a_end_y;
		logic signed [COORD_BITS-1:0] seg_b_start_x;
		logic signed [COORD_BITS-1:0] seg_b_start_y;
		logic signed [COORD_BITS-1:0] seg_b_end_x;
		logic signed [COORD_BITS-1:0] seg_b_end_y;
	} sit_req_t;

	typedef struct packed {
		logic       intersects;
		logic [2:0] hit_case;
	} sit_res_t;

	// load enables of the cross term stages
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} sit_adv_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sit_cross.sv =====
`default_nettype none

module sit_cross (
	input  wire logic                               clk,
	input  wire sit_pkg::sit_adv_t                  adv,
	input  wire logic signed [sit_pkg::DIF_W-1:0]   d_qp_y,
	input  wire logic signed [sit_pkg::DIF_W-1:0]   d_rq_x,
	input  wire logic signed [sit_pkg::DIF_W-1:0]   d_rq_y,
	input  wire logic signed [sit_pkg::DIF_W-1:0]   d_qp_x,
	input  wire logic [sit_pkg::TOL_BITS-1:0]       tol,
	output logic [1:0]                              ori_s5
);
	import sit_pkg::*;

	logic signed [PRD_W-1:0] t1_s3, t2_s3;
	logic signed [PRD_W-1:0] t1_d, t2_d;
	logic signed [CRS_W-1:0] val_s4;
	logic signed [CRS_W-1:0] tol_e;

	// both products of the cross term
	assign t1_d = d_qp_y * d_rq_x;
	assign t2_d = d_rq_y * d_qp_x;

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			t1_s3 <= t1_d;
			t2_s3 <= t2_d;
		end
	end

	// cross term
	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			val_s4 <= CRS_W'(t1_s3) - CRS_W'(t2_s3);
		end
	end

	// dead band classification
	assign tol_e = signed'(CRS_W'(tol));

	always_ff @(posedge clk) begin
		if (adv.en_s5) begin
			if (val_s4 < -tol_e) begin
				ori_s5 <= ORI_NEG;
			end else if (val_s4 > tol_e) begin
				ori_s5 <= ORI_POS;
			end else begin
				ori_s5 <= ORI_ZERO;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/segment_intersection_test.sv =====
// Segment intersection test: takes a pair of 2D segments (eight signed Q11.20
// coordinates) per request and returns one result telling whether the segments,
// each first shrunk inward by shrink_amount, intersect and which case fired.
// A new request can be taken every clock cycle unless an output stall fills the
// pipeline; each result passes through six register stages, the first loaded at
// the edge that accepts its request, and is presented from the last. The pipeline
// stages are: shrink, differences and box tests, products, cross term,
// orientation against orient_tolerance, and the final decision into the output
// register. The product stage holds eight signed 34x34 multipliers and sets the
// depth of the pipeline. Stalls ripple back stage by stage, so empty stages
// keep filling while a result waits at the output. Configuration writes are
// meant for idle times only and take effect on the next request.
`default_nettype none

module segment_intersection_test (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [sit_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [sit_pkg::CFG_W-1:0]             cfg_wdata,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire sit_pkg::sit_req_t                     in_req,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output sit_pkg::sit_res_t                          out_res
);
	import sit_pkg::*;

	// strict betweenness on one axis
	function automatic logic between(input logic signed [SH_W-1:0] a,
	                                 input logic signed [SH_W-1:0] b,
	                                 input logic signed [SH_W-1:0] c);
		between = ((a < b) && (b < c)) || ((c < b) && (b < a));
	endfunction

	logic [SHRINK_BITS-1:0] shrink_q;
	logic [TOL_BITS-1:0]    tol_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic signed [SH_W-1:0] amt;
	logic signed [SH_W-1:0] a1x_d, a1y_d, a2x_d, a2y_d, b1x_d, b1y_d, b2x_d, b2y_d;
	logic signed [SH_W-1:0] a1x_s1, a1y_s1, a2x_s1, a2y_s1;
	logic signed [SH_W-1:0] b1x_s1, b1y_s1, b2x_s1, b2y_s1;

	logic signed [DIF_W-1:0] ady_s2, adx_s2, bdy_s2, bdx_s2;
	logic signed [DIF_W-1:0] b1a2x_s2, b1a2y_s2, b2a2x_s2, b2a2y_s2;
	logic signed [DIF_W-1:0] a1b2x_s2, a1b2y_s2, a2b2x_s2, a2b2y_s2;
	logic [3:0] ins_s2, ins_s3, ins_s4, ins_s5;

	sit_adv_t adv;
	logic [1:0] o1_s5, o2_s5, o3_s5, o4_s5;
	logic [2:0] hit_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shrink_q <= SHRINK_RST;
			tol_q    <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHRINK: shrink_q <= cfg_wdata[SHRINK_BITS-1:0];
				REG_TOL:    tol_q    <= cfg_wdata[TOL_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// stall chain: a stage loads when empty or when the next one moves
	assign rdy6     = !v_s6 || !out_stall;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// shrink each axis toward the other endpoint
	assign amt = signed'(SH_W'(shrink_q));

	always_comb begin
		a1x_d = SH_W'(in_req.seg_a_start_x);
		a1y_d = SH_W'(in_req.seg_a_start_y);
		a2x_d = SH_W'(in_req.seg_a_end_x);
		a2y_d = SH_W'(in_req.seg_a_end_y);
		b1x_d = SH_W'(in_req.seg_b_start_x);
		b1y_d = SH_W'(in_req.seg_b_start_y);
		b2x_d = SH_W'(in_req.seg_b_end_x);
		b2y_d = SH_W'(in_req.seg_b_end_y);
		if (in_req.seg_a_end_x > in_req.seg_a_start_x) begin
			a1x_d = a1x_d + amt;
			a2x_d = a2x_d - amt;
		end else begin
			a1x_d = a1x_d - amt;
			a2x_d = a2x_d + amt;
		end
		if (in_req.seg_a_end_y > in_req.seg_a_start_y) begin
			a1y_d = a1y_d + amt;
			a2y_d = a2y_d - amt;
		end else begin
			a1y_d = a1y_d - amt;
			a2y_d = a2y_d + amt;
		end
		if (in_req.seg_b_end_x > in_req.seg_b_start_x) begin
			b1x_d = b1x_d + amt;
			b2x_d = b2x_d - amt;
		end else begin
			b1x_d = b1x_d - amt;
			b2x_d = b2x_d + amt;
		end
		if (in_req.seg_b_end_y > in_req.seg_b_start_y) begin
			b1y_d = b1y_d + amt;
			b2y_d = b2y_d - amt;
		end else begin
			b1y_d = b1y_d - amt;
			b2y_d = b2y_d + amt;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			a1x_s1 <= a1x_d;
			a1y_s1 <= a1y_d;
			a2x_s1 <= a2x_d;
			a2y_s1 <= a2y_d;
			b1x_s1 <= b1x_d;
			b1y_s1 <= b1y_d;
			b2x_s1 <= b2x_d;
			b2y_s1 <= b2y_d;
		end
	end

	// coordinate differences and strict inside-box tests
	always_ff @(posedge clk) begin
		if (rdy2) begin
			ady_s2   <= DIF_W'(a2y_s1) - DIF_W'(a1y_s1);
			adx_s2   <= DIF_W'(a2x_s1) - DIF_W'(a1x_s1);
			bdy_s2   <= DIF_W'(b2y_s1) - DIF_W'(b1y_s1);
			bdx_s2   <= DIF_W'(b2x_s1) - DIF_W'(b1x_s1);
			b1a2x_s2 <= DIF_W'(b1x_s1) - DIF_W'(a2x_s1);
			b1a2y_s2 <= DIF_W'(b1y_s1) - DIF_W'(a2y_s1);
			b2a2x_s2 <= DIF_W'(b2x_s1) - DIF_W'(a2x_s1);
			b2a2y_s2 <= DIF_W'(b2y_s1) - DIF_W'(a2y_s1);
			a1b2x_s2 <= DIF_W'(a1x_s1) - DIF_W'(b2x_s1);
			a1b2y_s2 <= DIF_W'(a1y_s1) - DIF_W'(b2y_s1);
			a2b2x_s2 <= DIF_W'(a2x_s1) - DIF_W'(b2x_s1);
			a2b2y_s2 <= DIF_W'(a2y_s1) - DIF_W'(b2y_s1);
			ins_s2[0] <= between(a1x_s1, b1x_s1, a2x_s1) && between(a1y_s1, b1y_s1, a2y_s1);
			ins_s2[1] <= between(a1x_s1, b2x_s1, a2x_s1) && between(a1y_s1, b2y_s1, a2y_s1);
			ins_s2[2] <= between(b1x_s1, a1x_s1, b2x_s1) && between(b1y_s1, a1y_s1, b2y_s1);
			ins_s2[3] <= between(b1x_s1, a2x_s1, b2x_s1) && between(b1y_s1, a2y_s1, b2y_s1);
		end
	end

	// box test flags ride along with the cross term stages
	always_ff @(posedge clk) begin
		if (rdy3) ins_s3 <= ins_s2;
		if (rdy4) ins_s4 <= ins_s3;
		if (rdy5) ins_s5 <= ins_s4;
	end

	assign adv.en_s3 = rdy3;
	assign adv.en_s4 = rdy4;
	assign adv.en_s5 = rdy5;

	// four orientations
	sit_cross u_o1 (
		.clk    (clk),
		.adv    (adv),
		.d_qp_y (ady_s2),
		.d_rq_x (b1a2x_s2),
		.d_rq_y (b1a2y_s2),
		.d_qp_x (adx_s2),
		.tol    (tol_q),
		.ori_s5 (o1_s5)
	);

	sit_cross u_o2 (
		.clk    (clk),
		.adv    (adv),
		.d_qp_y (ady_s2),
		.d_rq_x (b2a2x_s2),
		.d_rq_y (b2a2y_s2),
		.d_qp_x (adx_s2),
		.tol    (tol_q),
		.ori_s5 (o2_s5)
	);

	sit_cross u_o3 (
		.clk    (clk),
		.adv    (adv),
		.d_qp_y (bdy_s2),
		.d_rq_x (a1b2x_s2),
		.d_rq_y (a1b2y_s2),
		.d_qp_x (bdx_s2),
		.tol    (tol_q),
		.ori_s5 (o3_s5)
	);

	sit_cross u_o4 (
		.clk    (clk),
		.adv    (adv),
		.d_qp_y (bdy_s2),
		.d_rq_x (a2b2x_s2),
		.d_rq_y (a2b2y_s2),
		.d_qp_x (bdx_s2),
		.tol    (tol_q),
		.ori_s5 (o4_s5)
	);

	// first case that holds wins
	always_comb begin
		if ((o1_s5 != o2_s5) && (o3_s5 != o4_s5)) begin
			hit_d = HIT_GENERAL;
		end else if ((o1_s5 == ORI_ZERO) && ins_s5[0]) begin
			hit_d = HIT_B_START;
		end else if ((o2_s5 == ORI_ZERO) && ins_s5[1]) begin
			hit_d = HIT_B_END;
		end else if ((o3_s5 == ORI_ZERO) && ins_s5[2]) begin
			hit_d = HIT_A_START;
		end else if ((o4_s5 == ORI_ZERO) && ins_s5[3]) begin
			hit_d = HIT_A_END;
		end else begin
			hit_d = HIT_NONE;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (rdy6) begin
			out_res.intersects <= (hit_d != HIT_NONE);
			out_res.hit_case   <= hit_d;
		end
	end

	assign out_valid = v_s6;

`ifndef ASSERT_OFF
	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.intersects == (out_res.hit_case != HIT_NONE)))
		else $error("intersects flag disagrees with hit case");

	a_case_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.hit_case <= HIT_A_END))
		else $error("hit case out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_stall))
		else $error("input stalled while the pipeline has a free stage");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !(v_s6 && out_stall)) |=> v_s6)
		else $error("result lost between last stages");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/intersection_monitor.sv =====
`timescale 1ns / 100ps

module intersection_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sit_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sit_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  sit_pkg::sit_req_t                in_req,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  sit_pkg::sit_res_t                out_res,
	output int                               fail_count,
	output int                               pending,
	output int                               checked_count,
	output int                               general_count,
	output int                               colinear_count
);
	import sit_pkg::*;

	// local copy of the two registers
	logic [SHRINK_BITS-1:0] shrink_step;
	logic [TOL_BITS-1:0]    tol_band;

	// results still owed by the block, oldest first
	sit_res_t expected_hits[$];

	// endpoint coordinate after the inward move
	function automatic longint moved(longint s, longint e, bit at_end);
		longint d;
		d = (e - s > 0) ? longint'(shrink_step) : -longint'(shrink_step);
		return at_end ? e - d : s + d;
	endfunction

	// orientation of r against the line p->q, with dead band
	function automatic logic [1:0] turn_of(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		logic signed [127:0] dy_pq, dx_qr, dy_qr, dx_pq, cross_term, band;
		dy_pq = qy - py;
		dx_qr = rx - qx;
		dy_qr = ry - qy;
		dx_pq = qx - px;
		cross_term = dy_pq * dx_qr - dy_qr * dx_pq;
		band  = 128'(tol_band);
		if (cross_term < -band)
			return ORI_NEG;
		else if (cross_term > band)
			return ORI_POS;
		return ORI_ZERO;
	endfunction

	// b strictly inside the box spanned by a and c
	function automatic bit strictly_between(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		longint lo_x, hi_x, lo_y, hi_y;
		lo_x = (ax < cx) ? ax : cx;
		hi_x = (ax < cx) ? cx : ax;
		lo_y = (ay < cy) ? ay : cy;
		hi_y = (ay < cy) ? cy : ay;
		return bx > lo_x && bx < hi_x && by > lo_y && by < hi_y;
	endfunction

	function automatic sit_res_t intersection_of(sit_req_t r);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		longint a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
		logic [1:0] o1, o2, o3, o4;
		sit_res_t res;
		ax0 = longint'(signed'(r.seg_a_start_x));
		ay0 = longint'(signed'(r.seg_a_start_y));
		ax1 = longint'(signed'(r.seg_a_end_x));
		ay1 = longint'(signed'(r.seg_a_end_y));
		bx0 = longint'(signed'(r.seg_b_start_x));
		by0 = longint'(signed'(r.seg_b_start_y));
		bx1 = longint'(signed'(r.seg_b_end_x));
		by1 = longint'(signed'(r.seg_b_end_y));
		a1x = moved(ax0, ax1, 1'b0);
		a2x = moved(ax0, ax1, 1'b1);
		a1y = moved(ay0, ay1, 1'b0);
		a2y = moved(ay0, ay1, 1'b1);
		b1x = moved(bx0, bx1, 1'b0);
		b2x = moved(bx0, bx1, 1'b1);
		b1y = moved(by0, by1, 1'b0);
		b2y = moved(by0, by1, 1'b1);
		o1 = turn_of(a1x, a1y, a2x, a2y, b1x, b1y);
		o2 = turn_of(a1x, a1y, a2x, a2y, b2x, b2y);
		o3 = turn_of(b1x, b1y, b2x, b2y, a1x, a1y);
		o4 = turn_of(b1x, b1y, b2x, b2y, a2x, a2y);
		// first case that holds wins
		if (o1 != o2 && o3 != o4)
			res.hit_case = HIT_GENERAL;
		else if (o1 == ORI_ZERO && strictly_between(a1x, a1y, b1x, b1y, a2x, a2y))
			res.hit_case = HIT_B_START;
		else if (o2 == ORI_ZERO && strictly_between(a1x, a1y, b2x, b2y, a2x, a2y))
			res.hit_case = HIT_B_END;
		else if (o3 == ORI_ZERO && strictly_between(b1x, b1y, a1x, a1y, b2x, b2y))
			res.hit_case = HIT_A_START;
		else if (o4 == ORI_ZERO && strictly_between(b1x, b1y, a2x, a2y, b2x, b2y))
			res.hit_case = HIT_A_END;
		else
			res.hit_case = HIT_NONE;
		res.intersects = (res.hit_case != HIT_NONE);
		return res;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		sit_res_t want;
		if (!arst_n) begin
			shrink_step    <= SHRINK_RST;
			tol_band       <= TOL_RST;
			expected_hits.delete();
			fail_count     <= 0;
			pending        <= 0;
			checked_count  <= 0;
			general_count  <= 0;
			colinear_count <= 0;
		end else begin
			// result side
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: unexpected result intersects=%0b hit_case=%0d",
						$time, out_res.intersects, out_res.hit_case);
				end else begin
					want = expected_hits.pop_front();
					checked_count <= checked_count + 1;
					if (out_res.intersects !== want.intersects ||
							out_res.hit_case !== want.hit_case) begin
						fail_count <= fail_count + 1;
						$display("%0t: mismatch expected intersects=%0b hit_case=%0d, %s%0b %s%0d",
							$time, want.intersects, want.hit_case,
							"got intersects=", out_res.intersects,
							"hit_case=", out_res.hit_case);
					end
					if (want.hit_case == HIT_GENERAL)
						general_count <= general_count + 1;
					else if (want.hit_case != HIT_NONE)
						colinear_count <= colinear_count + 1;
				end
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == REG_SHRINK)
					shrink_step <= cfg_wdata[SHRINK_BITS-1:0];
				else if (cfg_index == REG_TOL)
					tol_band <= cfg_wdata[TOL_BITS-1:0];
			end
			// request side
			if (in_valid && !in_stall)
				expected_hits.push_back(intersection_of(in_req));
			pending <= expected_hits.size();
		end
	end

endmodule

// ===== tb/sv/tb_segment_intersection_test.sv =====
`timescale 1ns / 100ps

module tb_segment_intersection_test;
	import sit_pkg::*;

	localparam int PHASES          = 8;
	localparam int PAIRS_PER_PHASE = 100;
	localparam int LATENCY         = 6;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int UNIT            = 1 << 20;
	localparam int MAXC            = 32'h7FFFFFFF;
	localparam int MINC            = int'(32'h80000000);

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	sit_req_t             in_req;
	logic                 out_valid;
	logic                 out_stall;
	sit_res_t             out_res;

	int fail_count, pending, checked_count, general_count, colinear_count;
	int cycles;
	bit calm;

	segment_intersection_test uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	intersection_monitor chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_req         (in_req),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_res        (out_res),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked_count  (checked_count),
		.general_count  (general_count),
		.colinear_count (colinear_count)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d results outstanding", $time, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side back-pressure, drawn per result
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = calm ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	function automatic sit_req_t pair_of(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		sit_req_t r;
		r.seg_a_start_x = ax0;
		r.seg_a_start_y = ay0;
		r.seg_a_end_x   = ax1;
		r.seg_a_end_y   = ay1;
		r.seg_b_start_x = bx0;
		r.seg_b_start_y = by0;
		r.seg_b_end_x   = bx1;
		r.seg_b_end_y   = by1;
		return r;
	endfunction

	function automatic int spread_of(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// mostly scattered, colinear and shared-endpoint pairs near a random center, some noise
	function automatic sit_req_t random_pair();
		int kind, cx, cy, span, step, dx, dy, t, k;
		int px[4], py[4];
		kind = $urandom_range(0, 99);
		cx   = int'($urandom_range(0, 1 << 29)) - (1 << 28);
		cy   = int'($urandom_range(0, 1 << 29)) - (1 << 28);
		if (kind < 15)
			return pair_of($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		span = 1 << $urandom_range(2, 26);
		for (k = 0; k < 4; k++) begin
			px[k] = cx + spread_of(span);
			py[k] = cy + spread_of(span);
		end
		if (kind >= 55 && kind < 85) begin
			// points on one line, sometimes nudged off it
			case ($urandom_range(0, 4))
				0: begin dx = 1; dy = 0; end
				1: begin dx = 0; dy = 1; end
				2: begin dx = 1; dy = 1; end
				3: begin dx = 1; dy = -1; end
				default: begin
					dx = int'($urandom_range(0, 6)) - 3;
					dy = int'($urandom_range(0, 6)) - 3;
				end
			endcase
			step = $urandom_range(1, 1 << 14);
			for (k = 0; k < 4; k++) begin
				t = int'($urandom_range(0, 128)) - 64;
				px[k] = cx + t * step * dx;
				py[k] = cy + t * step * dy;
				if ($urandom_range(0, 2) == 0) begin
					px[k] += spread_of(2);
					py[k] += spread_of(2);
				end
			end
		end else if (kind >= 85) begin
			// shared endpoints and zero-length segments
			case ($urandom_range(0, 4))
				0: begin px[2] = px[0]; py[2] = py[0]; end
				1: begin px[2] = px[1]; py[2] = py[1]; end
				2: begin px[1] = px[0]; py[1] = py[0]; end
				3: begin px[3] = px[2]; py[3] = py[2]; end
				default: begin
					for (k = 1; k < 4; k++) begin
						px[k] = px[0] + spread_of(1);
						py[k] = py[0] + spread_of(1);
					end
				end
			endcase
		end
		return pair_of(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
	endfunction

	// present one request after a random gap and wait for it to be taken
	task automatic send_pair(sit_req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_req   = r;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop sending and wait for every owed result
	task automatic settle(bit before_write);
		@(negedge clk);
		in_valid = 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		if (before_write)
			repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_index = idx;
		cfg_wdata = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		int phase, i;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_SHRINK;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_req    = '0;
		calm      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pairs at reset register values
		send_pair(pair_of(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
		send_pair(pair_of(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
		send_pair(pair_of(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));
		send_pair(pair_of(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC));
		send_pair(pair_of(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
			32'h55555555, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA));
		// plain crossing
		send_pair(pair_of(0, 0, 10 * UNIT, 10 * UNIT, 0, 10 * UNIT, 10 * UNIT, 0));
		// colinear: B start inside A
		send_pair(pair_of(0, 0, 10 * UNIT, 10 * UNIT, 5 * UNIT, 5 * UNIT, 20 * UNIT, 20 * UNIT));
		// colinear: B end inside A
		send_pair(pair_of(0, 0, 10 * UNIT, 10 * UNIT, 20 * UNIT, 20 * UNIT, 5 * UNIT, 5 * UNIT));
		// colinear: A inside B
		send_pair(pair_of(3 * UNIT, 3 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0, 10 * UNIT, 10 * UNIT));
		// colinear: A end inside B, starts shared
		send_pair(pair_of(0, 0, 5 * UNIT, 5 * UNIT, 0, 0, 10 * UNIT, 10 * UNIT));
		// parallel, apart
		send_pair(pair_of(0, 0, 10 * UNIT, 0, 0, UNIT, 10 * UNIT, UNIT));
		// T junction
		send_pair(pair_of(0, 0, 10 * UNIT, 0, 5 * UNIT, 0, 5 * UNIT, 5 * UNIT));
		// everything at the origin
		send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
		// shrink carries endpoints past each other
		send_pair(pair_of(0, 0, 1, 1, 0, 1, 1, 0));
		// shared start, diverging
		send_pair(pair_of(UNIT, UNIT, 4 * UNIT, 2 * UNIT, UNIT, UNIT, 2 * UNIT, 4 * UNIT));
		// colinear, disjoint
		send_pair(pair_of(0, 0, UNIT, UNIT, 2 * UNIT, 2 * UNIT, 3 * UNIT, 3 * UNIT));
		// horizontal overlap
		send_pair(pair_of(0, 0, 10 * UNIT, 0, 5 * UNIT, 0, 15 * UNIT, 0));
		// B just short of A
		send_pair(pair_of(0, 0, 10 * UNIT, 0, 5 * UNIT, 4, 5 * UNIT, 5 * UNIT));
		// zero-length B sitting on A
		send_pair(pair_of(0, 0, 10 * UNIT, 10 * UNIT, 4 * UNIT, 4 * UNIT, 4 * UNIT, 4 * UNIT));
		// reversed A crossing B far from the origin
		send_pair(pair_of(-UNIT, MAXC, -3 * UNIT, MAXC - 4 * UNIT,
			-4 * UNIT, MAXC - UNIT, 0, MAXC - 3 * UNIT));

		// random pairs under a different register setting per phase
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				settle(1'b1);
				case (phase)
					1: begin
						write_reg(REG_SHRINK, '0);
						write_reg(REG_TOL, '0);
					end
					2: begin
						write_reg(REG_SHRINK, CFG_W'({SHRINK_BITS{1'b1}}));
						write_reg(REG_TOL, {TOL_BITS{1'b1}});
					end
					3: begin
						write_reg(REG_SHRINK, CFG_W'(SHRINK_RST));
						write_reg(REG_TOL, TOL_RST);
					end
					4: begin
						write_reg(REG_SHRINK, CFG_W'($urandom_range(0, 64)));
						write_reg(REG_TOL, CFG_W'($urandom_range(0, 1 << 24)));
					end
					5: begin
						write_reg(REG_SHRINK, {8'($urandom_range(0, 255)), 32'($urandom)});
						write_reg(REG_TOL, {8'($urandom_range(0, 255)), 32'($urandom)});
					end
					6: begin
						write_reg(REG_SHRINK, '0);
						write_reg(REG_TOL, TOL_RST);
					end
					default: begin
						write_reg(REG_SHRINK, CFG_W'($urandom_range(0, 4096)));
						write_reg(REG_TOL, '0);
					end
				endcase
			end
			for (i = 0; i < PAIRS_PER_PHASE; i++) begin
				if ($urandom_range(0, 39) == 0)
					calm = !calm;
				if ($urandom_range(0, 59) == 0)
					settle(1'b0);
				send_pair(random_pair());
			end
		end

		// drain and decide
		settle(1'b0);
		repeat (2 * LATENCY) @(posedge clk);
		$display("%0d segment pairs checked over %0d register settings", checked_count, PHASES);
		$display("%0d general crossings and %0d colinear overlaps among them",
			general_count, colinear_count);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
